@@ src/page_permission_map_unit_assert.svh @@
// Assertion macros shared by the page permission map modules
`ifndef PAGE_PERMISSION_MAP_UNIT_ASSERT_SVH
`define PAGE_PERMISSION_MAP_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// check a property on every clock edge outside reset
`define PPM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// check a property on every clock edge, reset included
`define PPM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PPM_ASSERT(lbl, prop, msg)
`define PPM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ src/ppm_pkg.sv @@
// Types and constants of the page permission map
`timescale 1ns / 1ps
`default_nettype none
package ppm_pkg;

	localparam int PPM_PAGE_BITS = 12;
	localparam int PPM_MAX_PAGES = 256;
	localparam int PPM_Q_DEPTH   = 2;

	localparam int ADDR_W   = 32;
	localparam int PCFG_W   = 9;
	localparam int IN_W     = 72;
	localparam int OUT_W    = 40;

	localparam logic [PCFG_W-1:0] PAGES_RESET = 9'd256;

	// command codes
	localparam logic [1:0] CMD_MAP    = 2'd0;
	localparam logic [1:0] CMD_UNMAP  = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_UNALIGNED = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	// work the back end does for one command
	typedef enum logic [1:0] {
		K_REPORT = 2'd0,
		K_FILL   = 2'd1,
		K_CLEAR  = 2'd2,
		K_READ   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		status_t           status;
		logic              warn;
		logic [1:0]        ptype;
		logic [ADDR_W-1:0] base;
	} ppm_op_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_FILL,
		B_UNMAP,
		B_READ,
		B_DONE
	} back_state_t;

endpackage
`default_nettype wire

@@ src/ppm_front.sv @@
// Front end: takes commands, holds the page count, classifies into queue entries
`timescale 1ns / 1ps
`default_nettype none
`include "page_permission_map_unit_assert.svh"
module ppm_front import ppm_pkg::*; #(
	parameter int PAGE_BITS = PPM_PAGE_BITS,
	parameter int MAX_PAGES = PPM_MAX_PAGES,
	localparam int IDX_W = $clog2(MAX_PAGES)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              clearing,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        in_cmd,
	input  wire logic [ADDR_W-1:0] in_start,
	input  wire logic [ADDR_W-1:0] in_end,
	input  wire logic [1:0]        in_ptype,
	input  wire logic              cfg_we,
	input  wire logic [PCFG_W-1:0] cfg_data,
	output logic                   q_valid,
	input  wire logic              q_ready,
	output ppm_op_t                q_op,
	output logic [IDX_W-1:0]       q_first,
	output logic [IDX_W-1:0]       q_last
);

	localparam logic [ADDR_W-1:0] OFF_MASK = (ADDR_W'(1) << PAGE_BITS) - ADDR_W'(1);
	localparam logic [ADDR_W-1:0] MAX_P    = ADDR_W'(MAX_PAGES);

	logic [PCFG_W-1:0] pages_q;
	logic              valid_s1;
	logic [1:0]        cmd_s1;
	logic [ADDR_W-1:0] start_s1;
	logic [ADDR_W-1:0] end_s1;
	logic [1:0]        ptype_s1;
	logic              accept;
	logic              push;
	logic [ADDR_W-1:0] limit;
	logic [ADDR_W-1:0] first_pg;
	logic [ADDR_W-1:0] last_pg;
	logic              start_off;
	logic              end_off;

	assign accept   = in_valid && in_ready;
	assign push     = valid_s1 && q_ready;
	assign in_ready = !clearing && (!valid_s1 || q_ready);
	assign q_valid  = valid_s1;

	// hold the page count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pages_q <= PAGES_RESET;
		end else if (cfg_we) begin
			pages_q <= cfg_data;
		end
	end

	// track the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// capture the command beat
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= in_cmd;
			start_s1 <= in_start;
			end_s1   <= in_end;
			ptype_s1 <= in_ptype;
		end
	end

	// usable pages: the smaller of the count and the table depth
	assign limit     = (ADDR_W'(pages_q) < MAX_P) ? ADDR_W'(pages_q) : MAX_P;
	assign first_pg  = start_s1 >> PAGE_BITS;
	assign last_pg   = (end_s1 - ADDR_W'(1)) >> PAGE_BITS;
	assign start_off = (start_s1 & OFF_MASK) != '0;
	assign end_off   = (end_s1 & OFF_MASK) != '0;
	assign q_first   = first_pg[IDX_W-1:0];
	assign q_last    = last_pg[IDX_W-1:0];

	// classify the command
	always_comb begin
		q_op        = '0;
		q_op.kind   = K_REPORT;
		q_op.status = ST_OK;
		q_op.ptype  = ptype_s1;
		unique case (cmd_s1)
			CMD_MAP: begin
				q_op.warn = start_off || end_off;
				if (end_s1 <= start_s1) begin
					q_op.status = ST_EMPTY;
				end else if (last_pg >= limit) begin
					q_op.status = ST_RANGE;
				end else begin
					q_op.kind = K_FILL;
				end
			end
			CMD_UNMAP: begin
				if (start_off) begin
					q_op.status = ST_UNALIGNED;
				end else if (first_pg >= limit) begin
					q_op.status = ST_RANGE;
				end else begin
					q_op.kind = K_CLEAR;
				end
			end
			CMD_LOOKUP: begin
				if (first_pg >= limit) begin
					q_op.status = ST_RANGE;
				end else begin
					q_op.kind = K_READ;
					q_op.base = start_s1 & ~OFF_MASK;
				end
			end
			default: begin
				q_op.kind = K_REPORT;
			end
		endcase
	end

	`PPM_ASSERT(a_no_take_clearing, (clearing |-> !in_ready), "command taken during clear")
	`PPM_ASSERT(a_stage_loaded, (accept |=> valid_s1), "accepted beat lost")

endmodule
`default_nettype wire

@@ src/ppm_fifo.sv @@
// Short queue between the front and back ends
`timescale 1ns / 1ps
`default_nettype none
`include "page_permission_map_unit_assert.svh"
module ppm_fifo import ppm_pkg::*; #(
	parameter int WIDTH = 8,
	localparam int PTR_W = (PPM_Q_DEPTH > 1) ? $clog2(PPM_Q_DEPTH) : 1,
	localparam int CNT_W = $clog2(PPM_Q_DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_valid,
	output logic                  wr_ready,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  rd_valid,
	input  wire logic             rd_ready,
	output logic [WIDTH-1:0]      rd_data
);

	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(PPM_Q_DEPTH - 1);

	logic [WIDTH-1:0] slot_q [PPM_Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign wr_ready = count_q != CNT_W'(PPM_Q_DEPTH);
	assign rd_valid = count_q != '0;
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;
	assign rd_data  = slot_q[rd_ptr_q];

	// store the entry
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`PPM_ASSERT_ALWAYS(a_count_bound, (count_q <= CNT_W'(PPM_Q_DEPTH)), "queue count overflow")

endmodule
`default_nettype wire

@@ src/ppm_back.sv @@
// Back end: owns the type table, runs map, unmap and lookup, drives the result register
`timescale 1ns / 1ps
`default_nettype none
`include "page_permission_map_unit_assert.svh"
module ppm_back import ppm_pkg::*; #(
	parameter int MAX_PAGES = PPM_MAX_PAGES,
	localparam int IDX_W = $clog2(MAX_PAGES)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	output logic                  clearing,
	input  wire logic             q_valid,
	output logic                  q_ready,
	input  wire ppm_op_t          q_op,
	input  wire logic [IDX_W-1:0] q_first,
	input  wire logic [IDX_W-1:0] q_last,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [OUT_W-1:0]      out_data
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PAGES - 1);

	logic [1:0]       types_mem [MAX_PAGES];
	back_state_t      state_q;
	back_state_t      state_d;
	ppm_op_t          op_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] last_q;
	logic [IDX_W-1:0] clr_q;
	logic [1:0]       rdata_q;
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;
	logic             pop;
	logic             idx_inc;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [1:0]       mem_wdata;
	logic             mem_re;
	logic             load_out;
	logic             out_free;
	logic             is_read;

	assign out_free  = !out_valid_q || out_ready;
	assign q_ready   = pop;
	assign clearing  = state_q == B_CLEAR;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign is_read   = op_q.kind == K_READ;

	// type table
	always_ff @(posedge clk) begin
		if (mem_we) begin
			types_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= types_mem[idx_q];
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and table controls
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		idx_inc   = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			B_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == LAST_IDX) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					unique case (q_op.kind)
						K_FILL:   state_d = B_FILL;
						K_CLEAR:  state_d = B_UNMAP;
						K_READ:   state_d = B_READ;
						K_REPORT: state_d = B_DONE;
						default:  state_d = B_DONE;
					endcase
				end
			end
			B_FILL: begin
				mem_we    = 1'b1;
				mem_wdata = op_q.ptype;
				if (idx_q == last_q) begin
					state_d = B_DONE;
				end else begin
					idx_inc = 1'b1;
				end
			end
			B_UNMAP: begin
				mem_we  = 1'b1;
				state_d = B_DONE;
			end
			B_READ: begin
				mem_re  = 1'b1;
				state_d = B_DONE;
			end
			B_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// sweep the table after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == B_CLEAR) begin
			clr_q <= clr_q + IDX_W'(1);
		end
	end

	// working copy of the command being run
	always_ff @(posedge clk) begin
		if (pop) begin
			op_q   <= q_op;
			idx_q  <= q_first;
			last_q <= q_last;
		end else if (idx_inc) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// pack status, warn, found, type and base from the low bit up
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= {2'b00, op_q.base, (is_read ? rdata_q : 2'b00), is_read,
				op_q.warn, op_q.status};
		end
	end

	`PPM_ASSERT(a_no_pop_clear, (clearing |-> !pop), "queue popped during clear")
	`PPM_ASSERT(a_fill_bound, ((state_q == B_FILL) |-> (idx_q <= last_q)), "fill ran past range")
	`PPM_ASSERT(a_done_loads, ((state_q == B_DONE && out_free) |=> out_valid_q),
		"result not presented")

endmodule
`default_nettype wire

@@ src/page_permission_map_unit.sv @@
// Page permission map: 2-bit access type per page with map, unmap and lookup
//
// Commands arrive on the s_axis channel: tuser carries the command (map, unmap,
// lookup), tdata the start address, the exclusive end address and the page type.
// Every command returns exactly one result beat on m_axis: status, unaligned
// warning, found flag, looked-up type and page base. cfg_wr_en writes the count
// of pages in use; write it only while no command is in flight.
// A command enters an input stage, is classified there and waits in a two-entry
// queue; the back end then runs it against the type table, one page per cycle.
// Lookup and unmap pass through one table state (read or write) before the result
// register, errors go straight to it and a map writes its pages in turn. The
// table port allows one page write per cycle.
// After reset the table is swept to not-present; no
// command is taken during the sweep. A stalled m_axis holds its result; the
// queue and input stage keep accepting until they fill, then s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none
module page_permission_map_unit import ppm_pkg::*; #(
	parameter int PAGE_BITS = PPM_PAGE_BITS,
	parameter int MAX_PAGES = PPM_MAX_PAGES
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	// start_addr[31:0], end_addr[63:32], page_type[65:64], zero pad
	input  wire logic [IN_W-1:0]   s_axis_tdata,
	// cmd[1:0]
	input  wire logic [1:0]        s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	// status[1:0], unaligned_warn[2], found[3], type_out[5:4], page_base[37:6], zero pad
	output logic [OUT_W-1:0]       m_axis_tdata,
	input  wire logic              cfg_wr_en,
	input  wire logic [PCFG_W-1:0] cfg_wr_data
);

	localparam int IDX_W = $clog2(MAX_PAGES);
	localparam int Q_W   = $bits(ppm_op_t) + 2 * IDX_W;

	logic             clearing;
	logic             f_valid;
	logic             f_ready;
	ppm_op_t          f_op;
	logic [IDX_W-1:0] f_first;
	logic [IDX_W-1:0] f_last;
	logic             b_valid;
	logic             b_ready;
	ppm_op_t          b_op;
	logic [IDX_W-1:0] b_first;
	logic [IDX_W-1:0] b_last;
	logic [Q_W-1:0]   q_wr_data;
	logic [Q_W-1:0]   q_rd_data;

	assign q_wr_data = {f_op, f_first, f_last};
	assign {b_op, b_first, b_last} = q_rd_data;

	ppm_front #(
		.PAGE_BITS(PAGE_BITS),
		.MAX_PAGES(MAX_PAGES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.clearing (clearing),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_cmd   (s_axis_tuser),
		.in_start (s_axis_tdata[31:0]),
		.in_end   (s_axis_tdata[63:32]),
		.in_ptype (s_axis_tdata[65:64]),
		.cfg_we   (cfg_wr_en),
		.cfg_data (cfg_wr_data),
		.q_valid  (f_valid),
		.q_ready  (f_ready),
		.q_op     (f_op),
		.q_first  (f_first),
		.q_last   (f_last)
	);

	ppm_fifo #(
		.WIDTH(Q_W)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (q_wr_data),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (q_rd_data)
	);

	ppm_back #(
		.MAX_PAGES(MAX_PAGES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clearing  (clearing),
		.q_valid   (b_valid),
		.q_ready   (b_ready),
		.q_op      (b_op),
		.q_first   (b_first),
		.q_last    (b_last),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
`default_nettype wire

@@ tb/page_permission_map_unit_test.sv @@
// Self-checking testbench of the page permission map: directed and random command traffic
`timescale 1ns / 1ps
module page_permission_map_unit_test;
	import ppm_pkg::*;

	// command code the block leaves unused
	localparam logic [1:0]  CMD_UNUSED = 2'd3;
	localparam logic [31:0] OFF_MASK   = (32'd1 << PPM_PAGE_BITS) - 32'd1;
	localparam int          PAGE_SIZE  = 1 << PPM_PAGE_BITS;

	typedef struct {
		status_t     status;
		logic        warn;
		logic        found;
		logic [1:0]  ptype;
		logic [31:0] base;
	} map_result_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata;
	logic [1:0]        s_axis_tuser;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [OUT_W-1:0]  m_axis_tdata;
	logic              cfg_wr_en;
	logic [PCFG_W-1:0] cfg_wr_data;

	// predictor state: page types and the page count register
	logic [1:0]        perm_table [PPM_MAX_PAGES];
	logic [PCFG_W-1:0] pages_in_use;
	map_result_t       expected_q [$];

	int unsigned fail_count;
	int unsigned beats_checked;
	int unsigned cfg_writes;
	int unsigned cmd_count [4];
	bit          steady_mode;
	int unsigned rdy_hold;
	bit          rdy_level;

	page_permission_map_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic int unsigned usable_page_count();
		return (pages_in_use < PPM_MAX_PAGES) ? int'(pages_in_use) : PPM_MAX_PAGES;
	endfunction

	// run one command against the table copy and return the result it gives
	function automatic map_result_t apply_page_cmd(logic [1:0] cmd, logic [31:0] sa,
			logic [31:0] ea, logic [1:0] pt);
		map_result_t r;
		int unsigned lim;
		int unsigned first_pg;
		int unsigned last_pg;
		int unsigned idx;
		r.status = ST_OK;
		r.warn   = 1'b0;
		r.found  = 1'b0;
		r.ptype  = 2'd0;
		r.base   = 32'd0;
		lim = usable_page_count();
		case (cmd)
			CMD_MAP: begin
				r.warn = ((sa & OFF_MASK) != 0) || ((ea & OFF_MASK) != 0);
				if (ea <= sa) begin
					r.status = ST_EMPTY;
				end else begin
					first_pg = sa >> PPM_PAGE_BITS;
					last_pg  = (ea - 32'd1) >> PPM_PAGE_BITS;
					if (last_pg >= lim) begin
						r.status = ST_RANGE;
					end else begin
						for (int unsigned p = first_pg; p <= last_pg; p++)
							perm_table[p] = pt;
					end
				end
			end
			CMD_UNMAP: begin
				idx = sa >> PPM_PAGE_BITS;
				if ((sa & OFF_MASK) != 0)
					r.status = ST_UNALIGNED;
				else if (idx >= lim)
					r.status = ST_RANGE;
				else
					perm_table[idx] = 2'd0;
			end
			CMD_LOOKUP: begin
				idx = sa >> PPM_PAGE_BITS;
				if (idx >= lim) begin
					r.status = ST_RANGE;
				end else begin
					r.found = 1'b1;
					r.ptype = perm_table[idx];
					r.base  = sa & ~OFF_MASK;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// mostly back-to-back or short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (steady_mode)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// send one command beat and record its expected result on acceptance
	task automatic send_cmd(logic [1:0] cmd, logic [31:0] sa, logic [31:0] ea, logic [1:0] pt);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, pt, ea, sa};
		s_axis_tuser  <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		expected_q.push_back(apply_page_cmd(cmd, sa, ea, pt));
		cmd_count[cmd]++;
	endtask

	// drop valid and hold until every result is back
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_page_count(logic [PCFG_W-1:0] v);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en    <= 1'b0;
		pages_in_use  = v;
		cfg_writes++;
	endtask

	// randomize result-side back pressure
	always @(posedge clk) begin : drive_ready
		int unsigned r;
		if (steady_mode) begin
			rdy_hold = 0;
			m_axis_tready <= 1'b1;
		end else begin
			if (rdy_hold == 0) begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					rdy_level = 1'b1;
					rdy_hold  = $urandom_range(1, 12);
				end else if (r < 92) begin
					rdy_level = 1'b0;
					rdy_hold  = $urandom_range(1, 3);
				end else begin
					rdy_level = 1'b0;
					rdy_hold  = $urandom_range(10, 40);
				end
			end else begin
				rdy_hold--;
			end
			m_axis_tready <= rdy_level;
		end
	end

	// compare each result beat with the oldest expected result
	always @(posedge clk) begin : check_beat
		map_result_t want;
		logic [1:0]  got_status;
		logic        got_warn;
		logic        got_found;
		logic [1:0]  got_type;
		logic [31:0] got_base;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_status = m_axis_tdata[1:0];
			got_warn   = m_axis_tdata[2];
			got_found  = m_axis_tdata[3];
			got_type   = m_axis_tdata[5:4];
			got_base   = m_axis_tdata[37:6];
			beats_checked++;
			if (expected_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("[%0t] unexpected result beat %h", $realtime, m_axis_tdata);
			end else begin
				want = expected_q.pop_front();
				if (got_status !== want.status || got_warn !== want.warn
						|| got_found !== want.found || got_type !== want.ptype
						|| got_base !== want.base) begin
					fail_count++;
					if (fail_count <= 10)
						$display("[%0t] mismatch: expected status %0d warn %0d found %0d ",
							$realtime, want.status, want.warn, want.found,
							"type %0d base %h, got status %0d warn %0d found %0d ",
							want.ptype, want.base, got_status, got_warn, got_found,
							"type %0d base %h", got_type, got_base);
				end
			end
		end
	end

	// table starts out all not-present
	task automatic test_reset_state();
		send_cmd(CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 2'd3);
		send_cmd(CMD_LOOKUP, 32'h000F_FFFF, 32'h0000_0000, 2'd0);
	endtask

	task automatic test_map_paths();
		send_cmd(CMD_MAP, 32'h0000_0000, 32'h0000_1000, 2'd3);
		// unaligned at both ends, touching pages one to three
		send_cmd(CMD_MAP, 32'h0000_1800, 32'h0000_3001, 2'd1);
		send_cmd(CMD_LOOKUP, 32'h0000_3FFF, 32'h0000_0000, 2'd0);
		// empty ranges, aligned and not
		send_cmd(CMD_MAP, 32'h0000_5000, 32'h0000_5000, 2'd2);
		send_cmd(CMD_MAP, 32'h0000_7001, 32'h0000_0010, 2'd2);
		// one byte past the last page
		send_cmd(CMD_MAP, 32'h000F_F000, 32'h0010_0001, 2'd2);
		send_cmd(CMD_MAP, 32'h000F_F000, 32'h0010_0000, 2'd2);
		send_cmd(CMD_LOOKUP, 32'h000F_FFFF, 32'h0000_0000, 2'd0);
		send_cmd(CMD_MAP, 32'hFFFF_F000, 32'hFFFF_FFFF, 2'd1);
	endtask

	task automatic test_unmap_paths();
		send_cmd(CMD_UNMAP, 32'h0000_1001, 32'h0000_0000, 2'd0);
		// alignment is checked ahead of the range
		send_cmd(CMD_UNMAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
		send_cmd(CMD_UNMAP, 32'h0000_1000, 32'h0000_0000, 2'd0);
		send_cmd(CMD_UNMAP, 32'h0010_0000, 32'h0000_0000, 2'd0);
		send_cmd(CMD_LOOKUP, 32'h0010_0000, 32'h0000_0000, 2'd0);
	endtask

	task automatic test_odd_commands();
		send_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
		// fill the whole table in one command
		send_cmd(CMD_MAP, 32'h0000_0000, 32'h0010_0000, 2'd2);
		send_cmd(CMD_LOOKUP, 32'h0008_0123, 32'h0000_0000, 2'd0);
		send_cmd(CMD_MAP, 32'h0000_0000, 32'hFFFF_FFFF, 2'd3);
	endtask

	task automatic test_page_limits();
		write_page_count(9'd0);
		send_cmd(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 2'd0);
		send_cmd(CMD_MAP, 32'h0000_0000, 32'h0000_1000, 2'd1);
		write_page_count(9'd1);
		send_cmd(CMD_LOOKUP, 32'h0000_0FFF, 32'h0000_0000, 2'd0);
		send_cmd(CMD_LOOKUP, 32'h0000_1000, 32'h0000_0000, 2'd0);
		// counts above the table size clip to it
		write_page_count(9'd511);
		send_cmd(CMD_LOOKUP, 32'h000F_FFFF, 32'h0000_0000, 2'd0);
		send_cmd(CMD_UNMAP, 32'h0010_0000, 32'h0000_0000, 2'd0);
		// shrink, then grow back: the upper pages keep their types
		write_page_count(9'd4);
		send_cmd(CMD_LOOKUP, 32'h0000_4000, 32'h0000_0000, 2'd0);
		write_page_count(PAGES_RESET);
		send_cmd(CMD_LOOKUP, 32'h000F_FABC, 32'h0000_0000, 2'd0);
	endtask

	function automatic logic [PCFG_W-1:0] pick_page_setting(int unsigned phase);
		int unsigned r;
		case (phase)
			0: return PAGES_RESET;
			1: return 9'd0;
			5: return 9'd511;
			default: begin
				r = $urandom_range(0, 99);
				if (r < 10)
					return PCFG_W'($urandom_range(1, 3));
				if (r < 20)
					return PCFG_W'($urandom_range(257, 511));
				if (r < 35)
					return PAGES_RESET;
				return PCFG_W'($urandom_range(4, 256));
			end
		endcase
	endfunction

	// addresses cluster on low pages or spread up to just past the limit, with some fully random
	function automatic logic [31:0] pick_addr(int unsigned lim);
		int unsigned page;
		int unsigned off;
		if ($urandom_range(0, 99) < 12)
			return $urandom();
		if ($urandom_range(0, 1) != 0)
			page = $urandom_range(0, (lim < 16) ? lim + 1 : 16);
		else
			page = $urandom_range(0, lim + 2);
		off = ($urandom_range(0, 99) < 65) ? 0 : $urandom_range(0, PAGE_SIZE - 1);
		return (page << PPM_PAGE_BITS) | off;
	endfunction

	// mostly short ranges, a few empty, random or very long ones
	function automatic logic [31:0] pick_map_end(logic [31:0] sa);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return sa - $urandom_range(0, 2 * PAGE_SIZE);
		if (r < 12)
			return $urandom();
		if (r < 13)
			return sa + ($urandom_range(16, PPM_MAX_PAGES) << PPM_PAGE_BITS);
		if (r < 60)
			return sa + ($urandom_range(1, 4) << PPM_PAGE_BITS);
		return sa + $urandom_range(1, 4 * PAGE_SIZE);
	endfunction

	task automatic test_random_traffic();
		int unsigned r;
		int unsigned lim;
		logic [1:0]  cmd;
		logic [31:0] sa;
		logic [31:0] ea;
		for (int unsigned phase = 0; phase < 12; phase++) begin
			write_page_count(pick_page_setting(phase));
			steady_mode = (phase % 4 == 3);
			lim = usable_page_count();
			for (int unsigned n = 0; n < 150; n++) begin
				r = $urandom_range(0, 99);
				if (r < 35)
					cmd = CMD_MAP;
				else if (r < 55)
					cmd = CMD_UNMAP;
				else if (r < 95)
					cmd = CMD_LOOKUP;
				else
					cmd = CMD_UNUSED;
				sa = pick_addr(lim);
				ea = (cmd == CMD_MAP) ? pick_map_end(sa) : $urandom();
				send_cmd(cmd, sa, ea, 2'($urandom()));
			end
		end
		steady_mode = 1'b0;
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		pages_in_use  = PAGES_RESET;
		fail_count    = 0;
		beats_checked = 0;
		cfg_writes    = 0;
		steady_mode   = 1'b0;
		rdy_hold      = 0;
		rdy_level     = 1'b0;
		foreach (cmd_count[i])
			cmd_count[i] = 0;
		foreach (perm_table[i])
			perm_table[i] = 2'd0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_map_paths();
		test_unmap_paths();
		test_odd_commands();
		test_page_limits();
		test_random_traffic();

		wait_idle();
		repeat (16) @(posedge clk);
		$display("Ran %0d map, %0d unmap, %0d lookup and %0d unused commands over %0d page counts",
			cmd_count[CMD_MAP], cmd_count[CMD_UNMAP], cmd_count[CMD_LOOKUP],
			cmd_count[CMD_UNUSED], cfg_writes);
		$display("Checked %0d result beats, %0d failures", beats_checked, fail_count);
		if (fail_count == 0 && expected_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// end a hung run
	initial begin
		#20_000_000;
		$display("Timeout with %0d results outstanding", expected_q.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+src
src/ppm_pkg.sv
src/ppm_front.sv
src/ppm_fifo.sv
src/ppm_back.sv
src/page_permission_map_unit.sv
tb/page_permission_map_unit_test.sv
